>>> hw/rtl/cowa_pkg.sv
// Shared codes and controller/datapath interface types for the offset averager.
`timescale 1ns / 1ps
package cowa_pkg;

   typedef enum logic [0:0] {
      OP_SYNC = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_UPDATED    = 2'd0,
      ST_SENT       = 2'd1,
      ST_NO_SYNC    = 2'd2,
      ST_NOT_JOINED = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic sub_old;
      logic add_new;
      logic prep;
      logic div_step;
      logic fix;
      logic tick;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic rsp_busy;
   } ctrl_sts_type;

endpackage

>>> hw/rtl/cowa_ctrl.sv
// Sequencing state machine for sync samples and send ticks.
`timescale 1ns / 1ps
module cowa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_operation,
   output logic                  req_ready,
   input  cowa_pkg::ctrl_sts_type sts,
   output cowa_pkg::ctrl_cmd_type cmd
);
   import cowa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SUB  = 8'b0000_0010,
      S_ADD  = 8'b0000_0100,
      S_PREP = 8'b0000_1000,
      S_DIV  = 8'b0001_0000,
      S_FIX  = 8'b0010_0000,
      S_TICK = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_operation == OP_SYNC) ? S_SUB : S_TICK;
            end
         end
         S_SUB: begin
            cmd.sub_old = 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.add_new = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_DONE;
         end
         S_TICK: begin
            cmd.tick = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

>>> hw/rtl/cowa_dpath.sv
// Offset ring, running sum, bit-serial divider, send counter and output register.
`timescale 1ns / 1ps
module cowa_dpath #(
   parameter int WINDOW = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cowa_pkg::ctrl_cmd_type cmd,
   output cowa_pkg::ctrl_sts_type sts,
   input  logic [31:0]            req_root_time,
   input  logic [31:0]            req_local_time,
   input  logic                   req_joined,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_average_offset,
   output logic [31:0]            rsp_corrected_time,
   output logic [31:0]            rsp_sequence_res
);
   import cowa_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = 32 + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);

   logic              joined_ff;
   logic [31:0]       root_ff, local_ff;
   logic [31:0]       ring_ff [WINDOW];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [31:0]       mean_ff, mean_in;
   logic              synced_ff, synced_in;
   logic [31:0]       seq_ff, seq_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [31:0]       res_corr_ff, res_corr_in;
   logic [31:0]       res_seq_ff, res_seq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [31:0]       rsp_avg_ff, rsp_corr_ff, rsp_seq_ff;

   logic [31:0]       offset;
   logic [31:0]       old_offset;
   logic [CNT_W:0]    shifted;
   logic [CNT_W+1:0]  trial;
   logic [33:0]       corr_sum;

   assign offset     = root_ff - local_ff;
   assign old_offset = ring_ff[slot_ff];
   assign shifted    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial      = {1'b0, shifted} - {2'b00, count_ff};
   assign corr_sum   = {2'b00, local_ff} + {{2{mean_ff[31]}}, mean_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         root_ff   <= req_root_time;
         local_ff  <= req_local_time;
         joined_ff <= req_joined;
      end
      if (cmd.add_new) begin
         ring_ff[slot_ff] <= offset;
      end
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      res_status_ff <= res_status_in;
      res_corr_ff   <= res_corr_in;
      res_seq_ff    <= res_seq_in;
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_avg_ff    <= mean_ff;
         rsp_corr_ff   <= res_corr_ff;
         rsp_seq_ff    <= res_seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         step_ff      <= '0;
         mean_ff      <= '0;
         synced_ff    <= 1'b0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         step_ff      <= step_in;
         mean_ff      <= mean_in;
         synced_ff    <= synced_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      mean_in       = mean_ff;
      synced_in     = synced_ff;
      seq_in        = seq_ff;
      res_status_in = res_status_ff;
      res_corr_in   = res_corr_ff;
      res_seq_in    = res_seq_ff;

      if (cmd.sub_old) begin
         if (count_ff == CNT_W'(WINDOW)) begin
            sum_in = sum_ff - {{(SUM_W-32){old_offset[31]}}, old_offset};
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.add_new) begin
         sum_in  = sum_ff + {{(SUM_W-32){offset[31]}}, offset};
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (cmd.prep) begin
         neg_in  = sum_ff[SUM_W-1];
         quo_in  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         step_in = step_ff + 1'b1;
         if (!trial[CNT_W+1]) begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (cmd.fix) begin
         mean_in       = neg_ff ? (~quo_ff[31:0] + 1'b1) : quo_ff[31:0];
         synced_in     = 1'b1;
         res_status_in = ST_UPDATED;
         res_corr_in   = '0;
         res_seq_in    = '0;
      end
      if (cmd.tick) begin
         res_corr_in = '0;
         res_seq_in  = '0;
         priority if (!synced_ff) begin
            res_status_in = ST_NO_SYNC;
         end else if (joined_ff) begin
            seq_in        = seq_ff + 1'b1;
            res_seq_in    = seq_ff + 1'b1;
            res_corr_in   = corr_sum[33] ? '0 : corr_sum[31:0];
            res_status_in = ST_SENT;
         end else begin
            res_status_in = ST_NOT_JOINED;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign sts.div_last = (step_ff == STEP_W'(SUM_W - 1));
   assign sts.rsp_busy = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_average_offset = rsp_avg_ff;
   assign rsp_corrected_time = rsp_corr_ff;
   assign rsp_sequence_res   = rsp_seq_ff;

endmodule

>>> hw/rtl/clock_offset_window_average_top.sv
// Sync sample / send tick block: window mean of clock offsets and corrected time stamps.
// A sync sample's word passes the subtract, add, prepare, divide and fix states after accept
// (the divider over the running sum takes one bit per cycle); a send tick's, the tick state.
// One word in flight: the next request can be accepted as soon as the word enters the output
// register; a waiting output word holds the controller.
// Synchronous active-high reset clears sum, count, slot, mean, sync flag, counter and
// handshake state; the offset ring is not cleared.
`timescale 1ns / 1ps
module clock_offset_window_average_top #(
   parameter int WINDOW = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [31:0]        req_root_time,
   input  logic [31:0]        req_local_time,
   input  logic               req_joined,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_average_offset,
   output logic [31:0]        rsp_corrected_time,
   output logic [31:0]        rsp_sequence_res
);
   import cowa_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   cowa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   cowa_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_root_time      (req_root_time),
      .req_local_time     (req_local_time),
      .req_joined         (req_joined),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_average_offset (rsp_average_offset),
      .rsp_corrected_time (rsp_corrected_time),
      .rsp_sequence_res   (rsp_sequence_res)
   );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the clock offset window averager: sync samples, send ticks, stalls.
`timescale 1ns / 1ps
module tb_top;
   import cowa_pkg::*;

   localparam int WIN         = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      status_type         status;
      logic signed [31:0] avg;
      logic [31:0]        corr;
      logic [31:0]        seq;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = 1'b0;
   logic [31:0]        req_root_time = '0;
   logic [31:0]        req_local_time = '0;
   logic               req_joined = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_average_offset;
   logic [31:0]        rsp_corrected_time;
   logic [31:0]        rsp_sequence_res;

   clock_offset_window_average_top #(.WINDOW(WIN)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_root_time(req_root_time),
      .req_local_time(req_local_time),
      .req_joined(req_joined),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_average_offset(rsp_average_offset),
      .rsp_corrected_time(rsp_corrected_time),
      .rsp_sequence_res(rsp_sequence_res)
   );

   // window averager state as the block should hold it
   logic [31:0] offset_hist [WIN];
   longint      window_sum = 0;
   int unsigned samples_held = 0;
   int unsigned next_slot = 0;
   int          mean_off = 0;
   bit          have_sync = 1'b0;
   logic [31:0] sends_done = '0;

   outcome_type pending_outcomes[$];
   outcome_type head_outcome;
   int          mismatches = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          n_updated = 0;
   int          n_sent = 0;
   int          n_no_sync = 0;
   int          n_not_joined = 0;
   int          cycles = 0;
   int          stall_left = 0;
   int          stall_len;
   bit          no_idle = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic outcome_type predict_outcome(op_type op, logic [31:0] root,
                                                   logic [31:0] loc, logic joined);
      outcome_type o;
      logic [31:0] diff;
      longint      stamp;
      o.status = ST_UPDATED;
      o.corr = '0;
      o.seq = '0;
      if (op == OP_SYNC) begin
         diff = root - loc;
         if (samples_held < WIN) samples_held++;
         else window_sum -= longint'(signed'(offset_hist[next_slot]));
         window_sum += longint'(signed'(diff));
         offset_hist[next_slot] = diff;
         next_slot = (next_slot + 1 == WIN) ? 0 : next_slot + 1;
         mean_off = int'(window_sum / longint'(samples_held));
         have_sync = 1'b1;
      end else if (!have_sync) begin
         o.status = ST_NO_SYNC;
      end else if (joined) begin
         sends_done = sends_done + 1;
         stamp = longint'(loc) + longint'(mean_off);
         o.corr = (stamp < 0) ? 32'd0 : stamp[31:0];
         o.seq = sends_done;
         o.status = ST_SENT;
      end else begin
         o.status = ST_NOT_JOINED;
      end
      o.avg = mean_off;
      return o;
   endfunction

   task automatic send_word(op_type op, logic [31:0] root, logic [31:0] loc, logic joined);
      int gap;
      req_operation  <= op;
      req_root_time  <= root;
      req_local_time <= loc;
      req_joined     <= joined;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(predict_outcome(op, root, loc, joined));
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected 0x%08h actual 0x%08h", $time, name, want, got);
      end
   endtask

   task automatic test_tick_before_sync();
      send_word(OP_TICK, 32'h0, 32'h0, 1'b0);
      send_word(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_word(OP_TICK, 32'h1234_5678, 32'h0000_0001, 1'b1);
   endtask

   task automatic test_window_extremes();
      send_word(OP_SYNC, 32'h0, 32'h0, 1'b0);
      send_word(OP_SYNC, 32'hFFFF_FFFF, 32'h0, 1'b1);
      send_word(OP_TICK, 32'h0, 32'h0, 1'b1);
      send_word(OP_SYNC, 32'h0, 32'hFFFF_FFFF, 1'b0);
      send_word(OP_SYNC, 32'h8000_0000, 32'h0, 1'b0);
      send_word(OP_SYNC, 32'h7FFF_FFFF, 32'h0, 1'b0);
      send_word(OP_SYNC, 32'h7FFF_FFFF, 32'h0, 1'b0);
      send_word(OP_SYNC, 32'h8000_0000, 32'h0, 1'b1);
      send_word(OP_TICK, 32'h0, 32'h0, 1'b0);
      send_word(OP_TICK, 32'h0, 32'h0, 1'b1);
      send_word(OP_TICK, 32'h0, 32'hFFFF_FFFF, 1'b1);
      for (int i = 0; i < WIN; i++) send_word(OP_SYNC, 32'h0, 32'd1000, 1'b0);
      send_word(OP_TICK, 32'h0, 32'd10, 1'b1);
      send_word(OP_TICK, 32'h0, 32'hFFFF_FFFF, 1'b1);
      for (int i = 0; i < WIN; i++) send_word(OP_SYNC, 32'd1000, 32'h0, 1'b0);
      send_word(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_random_mix(int count);
      logic [31:0] root;
      logic [31:0] loc;
      logic [31:0] delta;
      for (int i = 0; i < count; i++) begin
         loc = $urandom();
         root = $urandom();
         if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  delta = $urandom_range(0, 4000);
                  root = loc + delta - 32'd2000;
               end
               2: begin
                  root = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                  loc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
               end
               default: begin
                  delta = $urandom_range(0, 255);
                  root = loc + ($urandom_range(0, 1) ? 32'h7FFF_FF00 + delta
                                                     : 32'h8000_0000 + delta);
               end
            endcase
            send_word(OP_SYNC, root, loc, 1'($urandom_range(0, 1)));
         end else begin
            case ($urandom_range(0, 3))
               0: loc = $urandom_range(0, 3000);
               1: loc = 32'hFFFF_FFFF - $urandom_range(0, 3000);
               default: ;
            endcase
            send_word(OP_TICK, root, loc, $urandom_range(0, 9) < 7);
         end
      end
   endtask

   task automatic test_drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_len = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
         if (stall_len > 0) begin
            stall_left = stall_len - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: result word expected none actual status %0d", $time, rsp_status);
         end else begin
            head_outcome = pending_outcomes.pop_front();
            words_checked++;
            case (head_outcome.status)
               ST_UPDATED: n_updated++;
               ST_SENT:    n_sent++;
               ST_NO_SYNC: n_no_sync++;
               default:    n_not_joined++;
            endcase
            report_field("status", 32'(head_outcome.status), 32'(rsp_status));
            report_field("average_offset", head_outcome.avg, rsp_average_offset);
            report_field("corrected_time", head_outcome.corr, rsp_corrected_time);
            report_field("sequence_res", head_outcome.seq, rsp_sequence_res);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles,
                  pending_outcomes.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tick_before_sync();
      test_window_extremes();
      test_random_mix(775);
      test_drain_pause();
      no_idle = 1'b1;
      test_random_mix(200);
      no_idle = 1'b0;
      test_random_mix(575);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d words: %0d sync updates, %0d sends, %0d early ticks, %0d unjoined",
               words_sent, n_updated, n_sent, n_no_sync, n_not_joined);
      $display("%0d results checked, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cowa_pkg.sv
hw/rtl/cowa_ctrl.sv
hw/rtl/cowa_dpath.sv
hw/rtl/clock_offset_window_average_top.sv
bench/tb_top.sv
